>>> hdl/crcdf_pkg.sv
package crcdf_pkg;

    localparam int FRAME_LEN = 32;
    localparam int BODY_LEN  = FRAME_LEN - 4;
    localparam int FILL_W    = $clog2(FRAME_LEN + 1);
    localparam int IDX_W     = $clog2(FRAME_LEN);

    localparam logic [IDX_W-1:0] FIRST_BODY_IDX = IDX_W'(2);
    localparam logic [IDX_W-1:0] LAST_BODY_IDX  = IDX_W'(FRAME_LEN - 3);
    localparam logic [FILL_W-1:0] FILL_ALMOST   = FILL_W'(FRAME_LEN - 1);

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // configuration register indexes
    localparam logic REG_SYNC_FIRST  = 1'b0;
    localparam logic REG_SYNC_SECOND = 1'b1;

    typedef struct packed {
        logic [7:0]  body_byte;
        logic        last_of_frame;
        logic [31:0] frames_total;
        logic [31:0] resync_total;
    } t_qent;

    typedef struct packed {
        logic  push;
        t_qent ent;
    } t_qreq;

    // one byte of CRC-16/CCITT-FALSE, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> hdl/crcdf_front.sv
module crcdf_front
    import crcdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte,
    input  logic [7:0]  i_sync_first,
    input  logic [7:0]  i_sync_second,
    input  logic        i_q_full,
    output t_qreq       o_qreq
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CRC   = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [15:0]       r_crc, n_crc;
    logic [31:0]       r_frames, n_frames;
    logic [31:0]       r_resync, n_resync;
    logic [7:0]        r_win [FRAME_LEN];

    logic accept;
    logic pass;
    logic [7:0] cur_byte;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign cur_byte = r_win[r_idx];
    assign pass     = (r_win[0] == i_sync_first) && (r_win[1] == i_sync_second) &&
                      (r_crc == {r_win[FRAME_LEN-1], r_win[FRAME_LEN-2]});

    // window as a shift line: newest byte at the top, oldest at index 0 when full
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win[FRAME_LEN-1] <= i_byte;
            for (int j = 0; j < FRAME_LEN - 1; j++) begin
                r_win[j] <= r_win[j+1];
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_idx    = r_idx;
        n_crc    = r_crc;
        n_frames = r_frames;
        n_resync = r_resync;
        o_qreq.push               = 1'b0;
        o_qreq.ent.body_byte      = cur_byte;
        o_qreq.ent.last_of_frame  = (r_idx == LAST_BODY_IDX);
        o_qreq.ent.frames_total   = r_frames;
        o_qreq.ent.resync_total   = r_resync;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_fill == FILL_ALMOST) begin
                        n_fill  = FILL_W'(FRAME_LEN);
                        n_idx   = FIRST_BODY_IDX;
                        n_crc   = CRC_INIT;
                        n_state = S_CRC;
                    end else begin
                        n_fill = r_fill + FILL_W'(1);
                    end
                end
            end
            S_CRC: begin
                n_crc = crc_byte(r_crc, cur_byte);
                if (r_idx == LAST_BODY_IDX) begin
                    n_state = S_CHECK;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_CHECK: begin
                if (pass) begin
                    n_frames = r_frames + 32'd1;
                    n_idx    = FIRST_BODY_IDX;
                    n_state  = S_EMIT;
                end else begin
                    // drop the oldest byte; the next shift pushes it out
                    n_fill   = FILL_ALMOST;
                    n_resync = r_resync + 32'd1;
                    n_state  = S_IDLE;
                end
            end
            S_EMIT: begin
                if (!i_q_full) begin
                    o_qreq.push = 1'b1;
                    if (r_idx == LAST_BODY_IDX) begin
                        n_fill  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_frames <= '0;
            r_resync <= '0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_frames <= n_frames;
            r_resync <= n_resync;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_crc <= n_crc;
    end

endmodule

>>> hdl/crcdf_queue.sv
module crcdf_queue
    import crcdf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_qreq i_qreq,
    output logic  o_full,
    output logic  o_valid,
    output t_qent o_ent,
    input  logic  i_pop
);

    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    t_qent             r_mem [QDEPTH];

    logic do_push, do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_mem[r_rd];
    assign do_push = i_qreq.push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_qreq.ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
        end
    end

endmodule

>>> hdl/crcdf_back.sv
module crcdf_back
    import crcdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_qent       i_q_ent,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [71:0] o_data,
    output logic        o_last
);

    logic  r_valid;
    t_qent r_ent;

    // refill the output register when it is empty or being taken
    assign o_q_pop = i_q_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = {r_ent.resync_total, r_ent.frames_total, r_ent.body_byte};
    assign o_last  = r_ent.last_of_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ent <= i_q_ent;
        end
    end

endmodule

>>> hdl/sync_crc_frame_deframer.sv
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata[7:0] byte_in
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: body_byte, frames_total, resync_total;
//                                              tlast: last_of_frame
// cfg       in   i_cfg_we                      i_cfg_addr index, i_cfg_data value
//
// A byte that does not fill the window is stored. A byte that fills it starts a
// byte-serial CRC sweep over the body and a check before the next byte. On a pass the
// body goes out at one byte per cycle while the queue is not full, through a 4-entry queue
// and an output register; s_axis_tready stays low until the last body byte is queued.
// Synchronous active-low reset clears counters, fill and the queue; window bytes are
// not cleared. A stalled m_axis stalls only the emit sweep once the queue is full.
module sync_crc_frame_deframer
    import crcdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [7:0] body_byte, [39:8] frames_total,
                                        // [71:40] resync_total
    output logic        m_axis_tlast,   // last_of_frame
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0] r_sync_first;
    logic [7:0] r_sync_second;

    t_qreq qreq;
    t_qent q_ent;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= '0;
            r_sync_second <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                REG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    crcdf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_byte        (s_axis_tdata),
        .i_sync_first  (r_sync_first),
        .i_sync_second (r_sync_second),
        .i_q_full      (q_full),
        .o_qreq        (qreq)
    );

    crcdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qreq  (qreq),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_ent   (q_ent),
        .i_pop   (q_pop)
    );

    crcdf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_ent   (q_ent),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

endmodule
